// ----- design/uer_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_pkg
// Shared widths, codes, register indexes and stage records of the echo
// ranging block.
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int TIME_W     = 32;
  localparam int RANGE_W    = 16;
  localparam int HOLD_W     = 16;
  localparam int TMO_W      = 24;
  localparam int SUM_W      = 19;
  localparam int CNT_W      = 3;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  localparam int AVERAGE_COUNT = 5;

  localparam int MM_SCALE_W = 14;
  localparam logic [MM_SCALE_W-1:0] MM_PER_US_Q16 = 14'd11151;
  localparam int MM_FRAC    = 16;
  localparam int MM_PROD_W  = TIME_W + MM_SCALE_W;

  localparam logic [OP_W-1:0] OP_TRIGGER = 2'd0;
  localparam logic [OP_W-1:0] OP_ECHO    = 2'd1;
  localparam logic [OP_W-1:0] OP_POLL    = 2'd2;

  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_GOOD    = 2'd0;
  localparam status_t ST_BAD     = 2'd1;
  localparam status_t ST_TIMEOUT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 8'd3;

  localparam logic [RANGE_W-1:0] MIN_RANGE_RST = 16'd20;
  localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 16'd4000;
  localparam logic [HOLD_W-1:0]  HOLDOFF_RST   = 16'd100;
  localparam logic [TMO_W-1:0]   TIMEOUT_RST   = 24'd250000;

  typedef struct packed {
    logic [RANGE_W-1:0] min_range_mm;
    logic [RANGE_W-1:0] max_range_mm;
    logic [HOLD_W-1:0]  echo_holdoff_us;
    logic [TMO_W-1:0]   timeout_us;
  } cfg_t;

  typedef struct packed {
    logic              timeout;
    logic [TIME_W-1:0] width;
  } meas_t;

  typedef struct packed {
    logic               timeout;
    logic [TIME_W-1:0]  width;
    logic [RANGE_W-1:0] range;
  } scaled_t;

endpackage

// ----- design/uer_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_in_if
// Event channel: operation, echo level and microsecond timestamp.
// ----------------------------------------------------------------------------
interface uer_in_if;
  logic                       valid;
  logic                       ready;
  logic [uer_pkg::OP_W-1:0]   op;
  logic                       echo_level;
  logic [uer_pkg::TIME_W-1:0] time_us;

  modport source (output valid, op, echo_level, time_us, input ready);
  modport sink   (input valid, op, echo_level, time_us, output ready);
endinterface

// ----- design/uer_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_out_if
// Reading channel: status, ranges, pulse width and group mean.
// ----------------------------------------------------------------------------
interface uer_out_if;
  logic                        valid;
  logic                        ready;
  logic [uer_pkg::STATUS_W-1:0] status;
  logic [uer_pkg::RANGE_W-1:0] range_mm;
  logic [uer_pkg::TIME_W-1:0]  round_trip_us;
  logic                        average_valid;
  logic [uer_pkg::RANGE_W-1:0] average_mm;

  modport source (output valid, status, range_mm, round_trip_us, average_valid, average_mm,
                  input ready);
  modport sink   (input valid, status, range_mm, round_trip_us, average_valid, average_mm,
                  output ready);
endinterface

// ----- design/uer_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface uer_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [uer_pkg::CFG_IDX_W-1:0]  index;
  logic [uer_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/ultrasonic_echo_ranging.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranging
// Echo pulse-width ranging with bounds check and group averaging.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    op, echo_level, time_us
//   out_ch   out  valid/ready    status, range_mm, round_trip_us,
//                                average_valid, average_mm
//   cfg_ch   in   valid/ready    index, data (ready tied high)
//
// One event per cycle unless the output stalls; after its event is taken into
// the input register, a reading passes the tracking, scaling multiplier and
// result registers. Reset is synchronous, active low, and clears tracking,
// the last good range and the averaging group. A stalled result register
// backs up stage by stage; empty stages still take events.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranging #(
  parameter int AVERAGE_COUNT = uer_pkg::AVERAGE_COUNT
) (
  input  logic       clk,
  input  logic       rst_n,
  uer_in_if.sink     in_ch,
  uer_out_if.source  out_ch,
  uer_cfg_if.sink    cfg_ch
);

  uer_pkg::cfg_t    cfg;
  logic             meas_valid;
  logic             meas_ready;
  uer_pkg::meas_t   meas;
  logic             scaled_valid;
  logic             scaled_ready;
  uer_pkg::scaled_t scaled;

  uer_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  uer_event u_event (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg),
    .meas_valid (meas_valid),
    .meas_ready (meas_ready),
    .meas       (meas)
  );

  uer_scale u_scale (
    .clk          (clk),
    .rst_n        (rst_n),
    .meas_valid   (meas_valid),
    .meas_ready   (meas_ready),
    .meas         (meas),
    .scaled_valid (scaled_valid),
    .scaled_ready (scaled_ready),
    .scaled       (scaled)
  );

  uer_stats #(
    .AVERAGE_COUNT (AVERAGE_COUNT)
  ) u_stats (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .scaled_valid (scaled_valid),
    .scaled_ready (scaled_ready),
    .scaled       (scaled),
    .out_ch       (out_ch)
  );

endmodule

// ----- design/uer_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_cfg_regs
// Range bounds, echo holdoff and timeout registers.
// ----------------------------------------------------------------------------
module uer_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  uer_cfg_if.sink        cfg_ch,
  output uer_pkg::cfg_t  cfg
);

  uer_pkg::cfg_t cfg_r;
  uer_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        uer_pkg::CFG_MIN_RANGE: cfg_nxt.min_range_mm    = cfg_ch.data[uer_pkg::RANGE_W-1:0];
        uer_pkg::CFG_MAX_RANGE: cfg_nxt.max_range_mm    = cfg_ch.data[uer_pkg::RANGE_W-1:0];
        uer_pkg::CFG_HOLDOFF:   cfg_nxt.echo_holdoff_us = cfg_ch.data[uer_pkg::HOLD_W-1:0];
        uer_pkg::CFG_TIMEOUT:   cfg_nxt.timeout_us      = cfg_ch.data[uer_pkg::TMO_W-1:0];
        default:                cfg_nxt                 = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_range_mm    <= uer_pkg::MIN_RANGE_RST;
      cfg_r.max_range_mm    <= uer_pkg::MAX_RANGE_RST;
      cfg_r.echo_holdoff_us <= uer_pkg::HOLDOFF_RST;
      cfg_r.timeout_us      <= uer_pkg::TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- design/uer_event.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_event
// Input register and trigger/echo tracking; emits pulse widths and timeouts.
// ----------------------------------------------------------------------------
module uer_event (
  input  logic           clk,
  input  logic           rst_n,
  uer_in_if.sink         in_ch,
  input  uer_pkg::cfg_t  cfg,
  output logic           meas_valid,
  input  logic           meas_ready,
  output uer_pkg::meas_t meas
);

  logic                       in_v_r;
  logic [uer_pkg::OP_W-1:0]   op_r;
  logic                       level_r;
  logic [uer_pkg::TIME_W-1:0] time_r;

  logic                       trig_seen_r, trig_seen_nxt;
  logic                       echo_active_r, echo_active_nxt;
  logic [uer_pkg::TIME_W-1:0] trig_time_r, trig_time_nxt;
  logic [uer_pkg::TIME_W-1:0] start_time_r, start_time_nxt;

  logic                       a_v_r;
  uer_pkg::meas_t             a_r;

  logic                       a_en;
  logic                       in_en;
  logic                       fire;
  uer_pkg::meas_t             a_nxt;
  logic [uer_pkg::TIME_W-1:0] dt_trig;

  assign a_en        = !a_v_r || meas_ready;
  assign in_en       = !in_v_r || a_en;
  assign in_ch.ready = in_en;
  assign meas_valid  = a_v_r;
  assign meas        = a_r;
  assign dt_trig     = time_r - trig_time_r;

  always_comb begin
    trig_seen_nxt   = trig_seen_r;
    echo_active_nxt = echo_active_r;
    trig_time_nxt   = trig_time_r;
    start_time_nxt  = start_time_r;
    fire            = 1'b0;
    a_nxt.timeout   = 1'b0;
    a_nxt.width     = time_r - start_time_r;
    if (in_v_r && a_en) begin
      unique case (op_r)
        uer_pkg::OP_TRIGGER: begin
          trig_seen_nxt   = 1'b1;
          trig_time_nxt   = time_r;
          echo_active_nxt = 1'b0;
        end
        uer_pkg::OP_ECHO: begin
          if (level_r) begin
            if (trig_seen_r &&
                dt_trig > {{(uer_pkg::TIME_W-uer_pkg::HOLD_W){1'b0}}, cfg.echo_holdoff_us}) begin
              echo_active_nxt = 1'b1;
              start_time_nxt  = time_r;
            end
          end else if (echo_active_r) begin
            fire            = 1'b1;
            echo_active_nxt = 1'b0;
            trig_seen_nxt   = 1'b0;
          end
        end
        uer_pkg::OP_POLL: begin
          if (trig_seen_r &&
              dt_trig > {{(uer_pkg::TIME_W-uer_pkg::TMO_W){1'b0}}, cfg.timeout_us}) begin
            fire            = 1'b1;
            a_nxt.timeout   = 1'b1;
            a_nxt.width     = '0;
            trig_seen_nxt   = 1'b0;
            echo_active_nxt = 1'b0;
          end
        end
        default: fire = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r        <= 1'b0;
      a_v_r         <= 1'b0;
      trig_seen_r   <= 1'b0;
      echo_active_r <= 1'b0;
      trig_time_r   <= '0;
      start_time_r  <= '0;
    end else begin
      if (in_en) begin
        in_v_r <= in_ch.valid;
      end
      if (a_en) begin
        a_v_r <= in_v_r && fire;
      end
      trig_seen_r   <= trig_seen_nxt;
      echo_active_r <= echo_active_nxt;
      trig_time_r   <= trig_time_nxt;
      start_time_r  <= start_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_en && in_ch.valid) begin
      op_r    <= in_ch.op;
      level_r <= in_ch.echo_level;
      time_r  <= in_ch.time_us;
    end
    if (a_en) begin
      a_r <= a_nxt;
    end
  end

`ifndef SYNTHESIS
  a_echo_needs_trigger: assert property (@(posedge clk) disable iff (!rst_n)
    echo_active_r |-> trig_seen_r)
    else $error("echo active without a pending trigger");
`endif

endmodule

// ----- design/uer_scale.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_scale
// Pulse width to millimetres in Q16 fixed point, saturated to 16 bits.
// ----------------------------------------------------------------------------
module uer_scale (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             meas_valid,
  output logic             meas_ready,
  input  uer_pkg::meas_t   meas,
  output logic             scaled_valid,
  input  logic             scaled_ready,
  output uer_pkg::scaled_t scaled
);

  localparam int QW = uer_pkg::MM_PROD_W - uer_pkg::MM_FRAC;

  logic                          b_v_r;
  uer_pkg::scaled_t              b_r;
  logic                          b_en;
  logic [uer_pkg::MM_PROD_W-1:0] prod;
  logic [QW-1:0]                 quot;
  logic [uer_pkg::RANGE_W-1:0]   mm_sat;

  assign b_en         = !b_v_r || scaled_ready;
  assign meas_ready   = b_en;
  assign scaled_valid = b_v_r;
  assign scaled       = b_r;

  assign prod   = uer_pkg::MM_PROD_W'(meas.width) * uer_pkg::MM_PROD_W'(uer_pkg::MM_PER_US_Q16);
  assign quot   = prod[uer_pkg::MM_PROD_W-1:uer_pkg::MM_FRAC];
  assign mm_sat = (|quot[QW-1:uer_pkg::RANGE_W]) ? '1 : quot[uer_pkg::RANGE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_en) begin
      b_v_r <= meas_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_en && meas_valid) begin
      b_r.timeout <= meas.timeout;
      b_r.width   <= meas.width;
      b_r.range   <= mm_sat;
    end
  end

endmodule

// ----- design/uer_stats.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_stats
// Bounds check, last good range, group averaging and result register.
// ----------------------------------------------------------------------------
module uer_stats #(
  parameter int AVERAGE_COUNT = uer_pkg::AVERAGE_COUNT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  uer_pkg::cfg_t    cfg,
  input  logic             scaled_valid,
  output logic             scaled_ready,
  input  uer_pkg::scaled_t scaled,
  uer_out_if.source        out_ch
);

  localparam int RECIP_SHIFT = uer_pkg::SUM_W + uer_pkg::CNT_W;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << RECIP_SHIFT) + AVERAGE_COUNT - 1) / AVERAGE_COUNT);
  localparam int AVG_PROD_W  = uer_pkg::SUM_W + RECIP_W;
  localparam int N_W         = uer_pkg::CNT_W + 1;

  logic [uer_pkg::RANGE_W-1:0] last_good_r, last_good_nxt;
  logic [uer_pkg::CNT_W-1:0]   group_cnt_r, group_cnt_nxt;
  logic [uer_pkg::SUM_W-1:0]   group_sum_r, group_sum_nxt;

  logic                         out_v_r;
  uer_pkg::status_t             status_r, status_nxt;
  logic [uer_pkg::RANGE_W-1:0]  range_r;
  logic [uer_pkg::TIME_W-1:0]   width_r;
  logic                         avg_v_r;
  logic [uer_pkg::RANGE_W-1:0]  avg_r, avg_nxt;

  logic                         c_en;
  logic                         c_load;
  logic                         good;
  logic [uer_pkg::SUM_W-1:0]    sum_new;
  logic [N_W-1:0]               n;
  logic                         complete;
  logic [AVG_PROD_W-1:0]        avg_prod;

  assign c_en         = !out_v_r || out_ch.ready;
  assign c_load       = c_en && scaled_valid;
  assign scaled_ready = c_en;

  assign good = !scaled.timeout &&
                (scaled.range >= cfg.min_range_mm) && (scaled.range <= cfg.max_range_mm);

  always_comb begin
    if (scaled.timeout) begin
      status_nxt = uer_pkg::ST_TIMEOUT;
    end else if (good) begin
      status_nxt = uer_pkg::ST_GOOD;
    end else begin
      status_nxt = uer_pkg::ST_BAD;
    end
  end

  assign last_good_nxt = good ? scaled.range : last_good_r;
  assign sum_new       = group_sum_r + uer_pkg::SUM_W'(last_good_nxt);
  assign n             = {1'b0, group_cnt_r} + N_W'(1);
  assign complete      = n >= N_W'(AVERAGE_COUNT);
  assign avg_prod      = AVG_PROD_W'(sum_new) * AVG_PROD_W'(RECIP);
  assign avg_nxt       = complete ? avg_prod[RECIP_SHIFT +: uer_pkg::RANGE_W] : '0;
  assign group_cnt_nxt = complete ? '0 : n[uer_pkg::CNT_W-1:0];
  assign group_sum_nxt = complete ? '0 : sum_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r     <= 1'b0;
      last_good_r <= '0;
      group_cnt_r <= '0;
      group_sum_r <= '0;
    end else begin
      if (c_en) begin
        out_v_r <= scaled_valid;
      end
      if (c_load) begin
        last_good_r <= last_good_nxt;
        group_cnt_r <= group_cnt_nxt;
        group_sum_r <= group_sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_load) begin
      status_r <= status_nxt;
      range_r  <= last_good_nxt;
      width_r  <= scaled.width;
      avg_v_r  <= complete;
      avg_r    <= avg_nxt;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.status        = status_r;
  assign out_ch.range_mm      = range_r;
  assign out_ch.round_trip_us = width_r;
  assign out_ch.average_valid = avg_v_r;
  assign out_ch.average_mm    = avg_r;

`ifndef SYNTHESIS
  a_group_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, group_cnt_r} < N_W'(AVERAGE_COUNT))
    else $error("group count reached the group size");

  a_group_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (c_load && complete) |=> (group_cnt_r == '0) && (group_sum_r == '0))
    else $error("group not restarted after a mean");

  a_good_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && status_r == uer_pkg::ST_GOOD) |->
      (range_r >= cfg.min_range_mm) && (range_r <= cfg.max_range_mm))
    else $error("good reading outside range bounds");

  a_timeout_zero_width: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && status_r == uer_pkg::ST_TIMEOUT) |-> (width_r == '0))
    else $error("timeout reading with nonzero width");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives timestamped trigger, echo and poll events into the echo ranging
// block, predicts each reading (pulse width, scaled range, bounds check,
// timeout and group mean) and compares every reading field by field.
// Register settings change between phases, and both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import uer_pkg::*;

  localparam logic [OP_W-1:0]      OP_UNUSED     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST      = 8'hFF;
  localparam int                   STALL_LIMIT   = 4000;
  localparam int                   SETTLE_CYCLES = 8;
  localparam int                   PHASE_ITEMS   = 190;
  localparam int                   PACE_SPAN     = 40;
  localparam int                   PHASES        = 7;

  typedef struct packed {
    status_t             status;
    logic [RANGE_W-1:0]  range_mm;
    logic [TIME_W-1:0]   round_trip_us;
    logic                average_valid;
    logic [RANGE_W-1:0]  average_mm;
  } reading_t;

  class reading_tracker;
    logic [RANGE_W-1:0] min_mm;
    logic [RANGE_W-1:0] max_mm;
    logic [HOLD_W-1:0]  holdoff;
    logic [TMO_W-1:0]   timeout;
    bit                 armed;
    bit                 echo_high;
    logic [TIME_W-1:0]  trig_t;
    logic [TIME_W-1:0]  rise_t;
    logic [RANGE_W-1:0] last_mm;
    int unsigned        grp_n;
    logic [SUM_W-1:0]   grp_sum;
    reading_t           due[$];
    int                 errors;

    function new();
      min_mm    = MIN_RANGE_RST;
      max_mm    = MAX_RANGE_RST;
      holdoff   = HOLDOFF_RST;
      timeout   = TIMEOUT_RST;
      armed     = 1'b0;
      echo_high = 1'b0;
      trig_t    = '0;
      rise_t    = '0;
      last_mm   = '0;
      grp_n     = 0;
      grp_sum   = '0;
      errors    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MIN_RANGE: min_mm  = data[RANGE_W-1:0];
        CFG_MAX_RANGE: max_mm  = data[RANGE_W-1:0];
        CFG_HOLDOFF:   holdoff = data[HOLD_W-1:0];
        CFG_TIMEOUT:   timeout = data[TMO_W-1:0];
        default: ;
      endcase
    endfunction

    function void close_reading(status_t st, logic [TIME_W-1:0] width);
      reading_t r;
      grp_sum         = grp_sum + SUM_W'(last_mm);
      r.status        = st;
      r.range_mm      = last_mm;
      r.round_trip_us = width;
      r.average_valid = 1'b0;
      r.average_mm    = '0;
      if (grp_n + 1 >= AVERAGE_COUNT) begin
        r.average_valid = 1'b1;
        r.average_mm    = RANGE_W'(grp_sum / AVERAGE_COUNT);
        grp_n           = 0;
        grp_sum         = '0;
      end else begin
        grp_n = grp_n + 1;
      end
      due.push_back(r);
    endfunction

    function void take_event(logic [OP_W-1:0] op, logic lvl, logic [TIME_W-1:0] t);
      logic [TIME_W-1:0]  width;
      logic [47:0]        prod;
      logic [RANGE_W-1:0] mm;
      case (op)
        OP_TRIGGER: begin
          armed     = 1'b1;
          trig_t    = t;
          echo_high = 1'b0;
        end
        OP_ECHO: begin
          if (lvl) begin
            if (armed && (t - trig_t) > holdoff) begin
              echo_high = 1'b1;
              rise_t    = t;
            end
          end else if (echo_high) begin
            width     = t - rise_t;
            prod      = 48'(width) * MM_PER_US_Q16;
            mm        = (prod[47:MM_FRAC] > 32'h0000_FFFF) ? 16'hFFFF : prod[31:MM_FRAC];
            echo_high = 1'b0;
            armed     = 1'b0;
            if (mm >= min_mm && mm <= max_mm) begin
              last_mm = mm;
              close_reading(ST_GOOD, width);
            end else begin
              close_reading(ST_BAD, width);
            end
          end
        end
        OP_POLL: begin
          if (armed && (t - trig_t) > TIME_W'(timeout)) begin
            armed     = 1'b0;
            echo_high = 1'b0;
            close_reading(ST_TIMEOUT, '0);
          end
        end
        default: ;
      endcase
    endfunction

    function void compare(string field, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_reading(status_t st, logic [RANGE_W-1:0] rng, logic [TIME_W-1:0] rt,
                                logic av, logic [RANGE_W-1:0] am);
      reading_t want;
      if (due.size() == 0) begin
        $display("%0t: unexpected reading, expected none, got %0d/%0d/%0d/%0b/%0d",
                 $time, st, rng, rt, av, am);
        errors++;
        return;
      end
      want = due.pop_front();
      compare("status", TIME_W'(want.status), TIME_W'(st));
      compare("range_mm", TIME_W'(want.range_mm), TIME_W'(rng));
      compare("round_trip_us", want.round_trip_us, rt);
      compare("average_valid", TIME_W'(want.average_valid), TIME_W'(av));
      compare("average_mm", TIME_W'(want.average_mm), TIME_W'(am));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  uer_in_if  in_ch();
  uer_out_if out_ch();
  uer_cfg_if cfg_ch();

  ultrasonic_echo_ranging dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  reading_tracker tracker = new();

  int                 idle_pct = 15;
  int                 stall_pct = 15;
  int                 sink_hold = 0;
  int                 quiet_cycles = 0;
  int unsigned        items_sent = 0;
  logic [TIME_W-1:0]  now;
  logic [RANGE_W-1:0] cur_min = MIN_RANGE_RST;
  logic [RANGE_W-1:0] cur_max = MAX_RANGE_RST;
  logic [HOLD_W-1:0]  cur_hold = HOLDOFF_RST;
  logic [TMO_W-1:0]   cur_tmo = TIMEOUT_RST;
  int                 paces[3] = '{0, 15, 50};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_len(int pct);
    int r;
    if ($urandom_range(0, 99) >= pct) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // smallest pulse width that scales to at least mm
  function automatic logic [TIME_W-1:0] width_for(logic [RANGE_W:0] mm);
    return TIME_W'(((64'(mm) << MM_FRAC) + MM_PER_US_Q16 - 1) / MM_PER_US_Q16);
  endfunction

  function automatic logic [TIME_W-1:0] pick_width();
    int           sel;
    logic [RANGE_W:0] lo;
    logic [RANGE_W:0] hi;
    sel = $urandom_range(0, 99);
    lo  = {1'b0, cur_min};
    hi  = {1'b0, cur_max};
    if (sel < 45) begin
      if (lo <= hi) return width_for((RANGE_W+1)'($urandom_range(lo, hi))) + $urandom_range(0, 5);
      return width_for((RANGE_W+1)'($urandom_range(0, 65535))) + $urandom_range(0, 5);
    end
    if (sel < 52) return width_for(lo);
    if (sel < 58) return width_for(lo) - ((lo != 0) ? 1 : 0);
    if (sel < 64) return width_for(hi + 1'b1) - 1;
    if (sel < 70) return width_for(hi + 1'b1);
    if (sel < 78) return $urandom_range(0, 200);
    if (sel < 88) return $urandom_range(width_for(17'h10000), 32'hFFFF_FFFF);
    return $urandom();
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_hold    <= 0;
    end else if (sink_hold != 0) begin
      out_ch.ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      out_ch.ready <= 1'b1;
      sink_hold <= gap_len(stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        tracker.take_event(in_ch.op, in_ch.echo_level, in_ch.time_us);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        tracker.set_reg(cfg_ch.index, cfg_ch.data);
      end
      if (out_ch.valid && out_ch.ready) begin
        tracker.check_reading(out_ch.status, out_ch.range_mm, out_ch.round_trip_us,
                              out_ch.average_valid, out_ch.average_mm);
      end
      if ((in_ch.valid && in_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
          (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  task automatic send_event(logic [OP_W-1:0] op, logic lvl, logic [TIME_W-1:0] t);
    int gap;
    gap = gap_len(idle_pct);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.echo_level <= lvl;
    in_ch.time_us    <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op != OP_UNUSED) begin
      items_sent++;
      if (items_sent % PACE_SPAN == 0) begin
        idle_pct  = paces[$urandom_range(0, 2)];
        stall_pct = paces[$urandom_range(0, 2)];
      end
    end
  endtask

  // drain every pending reading, then let in-flight events clear
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic load_config(logic [RANGE_W-1:0] mn, logic [RANGE_W-1:0] mx,
                             logic [HOLD_W-1:0] hd, logic [TMO_W-1:0] tmo);
    write_reg(CFG_MIN_RANGE, {8'($urandom), mn});
    write_reg(CFG_MAX_RANGE, {8'($urandom), mx});
    write_reg(CFG_HOLDOFF, {8'($urandom), hd});
    write_reg(CFG_TIMEOUT, tmo);
    if ($urandom_range(0, 1) == 1) begin
      write_reg(CFG_IDX_W'($urandom_range(CFG_TIMEOUT + 1, CFG_LAST)), CFG_DATA_W'($urandom));
    end
    cfg_ch.valid <= 1'b0;
    cur_min  = mn;
    cur_max  = mx;
    cur_hold = hd;
    cur_tmo  = tmo;
  endtask

  task automatic reading_sequence();
    logic [TIME_W-1:0] t_trig;
    logic [TIME_W-1:0] t_rise;
    logic [TIME_W-1:0] w;
    t_trig = now;
    send_event(OP_TRIGGER, 1'($urandom), t_trig);
    if ($urandom_range(0, 3) == 0) begin
      send_event(OP_ECHO, 1'b1, t_trig + $urandom_range(0, cur_hold));
    end
    t_rise = t_trig + cur_hold + 1;
    if ($urandom_range(0, 3) != 0) t_rise = t_rise + $urandom_range(0, 400);
    send_event(OP_ECHO, 1'b1, t_rise);
    if ($urandom_range(0, 4) == 0) begin
      send_event(OP_POLL, 1'($urandom), t_rise + $urandom_range(0, 50));
    end
    if ($urandom_range(0, 9) == 0) begin
      t_rise = t_rise + $urandom_range(1, 100);
      send_event(OP_ECHO, 1'b1, t_rise);
    end
    w = pick_width();
    send_event(OP_ECHO, 1'b0, t_rise + w);
    if ($urandom_range(0, 6) == 0) begin
      send_event(OP_ECHO, 1'b0, t_rise + w + $urandom_range(1, 30));
    end
    now = t_rise + w + $urandom_range(1, 5000);
  endtask

  task automatic timeout_sequence();
    logic [TIME_W-1:0] t_trig;
    t_trig = now;
    send_event(OP_TRIGGER, 1'($urandom), t_trig);
    if ($urandom_range(0, 2) == 0) begin
      send_event(OP_POLL, 1'($urandom), t_trig + $urandom_range(0, cur_tmo));
    end
    if ($urandom_range(0, 3) == 0) begin
      send_event(OP_ECHO, 1'b1, t_trig + cur_hold + 1);
    end
    send_event(OP_POLL, 1'($urandom), t_trig + cur_tmo);
    send_event(OP_POLL, 1'($urandom), t_trig + cur_tmo + 1 + $urandom_range(0, 3));
    if ($urandom_range(0, 2) == 0) begin
      send_event(OP_POLL, 1'($urandom), t_trig + cur_tmo + 10);
    end
    now = t_trig + cur_tmo + $urandom_range(20, 5000);
  endtask

  initial begin
    logic [TIME_W-1:0]  t0;
    logic [TIME_W-1:0]  probe_w[3];
    logic [RANGE_W-1:0] mn;
    int                 sel;
    int unsigned        goal;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= OP_TRIGGER;
    in_ch.echo_level <= 1'b0;
    in_ch.time_us    <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_MIN_RANGE;
    cfg_ch.data      <= '0;
    now = $urandom();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // stray events with nothing pending, then the unused operation
    send_event(OP_POLL, 1'b1, 32'h0000_1000);
    send_event(OP_ECHO, 1'b0, 32'h0000_1010);
    send_event(OP_ECHO, 1'b1, 32'h0000_1020);
    send_event(OP_UNUSED, 1'b1, 32'hFFFF_FFFF);

    // holdoff boundary across the timestamp wrap, re-latched rise, minimum range
    t0 = 32'hFFFF_FFC0;
    send_event(OP_TRIGGER, 1'b1, t0);
    send_event(OP_ECHO, 1'b1, t0 + HOLDOFF_RST);
    send_event(OP_ECHO, 1'b0, t0 + 32'd120);
    send_event(OP_ECHO, 1'b1, t0 + HOLDOFF_RST + 1);
    send_event(OP_ECHO, 1'b1, t0 + 32'd140);
    send_event(OP_ECHO, 1'b0, t0 + 32'd140 + width_for({1'b0, MIN_RANGE_RST}));

    // maximum range, just past it, saturated width
    probe_w[0] = width_for({1'b0, MAX_RANGE_RST} + 1'b1) - 1;
    probe_w[1] = width_for({1'b0, MAX_RANGE_RST} + 1'b1);
    probe_w[2] = 32'hFFFF_FFFF;
    for (int i = 0; i < 3; i++) begin
      t0 = now;
      send_event(OP_TRIGGER, 1'b0, t0);
      send_event(OP_ECHO, 1'b1, t0 + 32'd1000);
      send_event(OP_ECHO, 1'b0, t0 + 32'd1000 + probe_w[i]);
      now = now + 32'd20000;
    end

    // timeout boundary, reported once
    t0 = now;
    send_event(OP_TRIGGER, 1'b0, t0);
    send_event(OP_POLL, 1'b0, t0 + TIMEOUT_RST);
    send_event(OP_POLL, 1'b1, t0 + TIMEOUT_RST + 1);
    send_event(OP_POLL, 1'b0, t0 + TIMEOUT_RST + 2);
    now = t0 + TIMEOUT_RST + 32'd100;

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: load_config(16'd0, 16'hFFFF, 16'd0, 24'd1);
        1: load_config(16'hFFFF, 16'd0, 16'hFFFF, 24'hFF_FFFF);
        2: begin
          mn = RANGE_W'($urandom_range(0, 6000));
          load_config(mn, mn, HOLD_W'($urandom_range(0, 300)),
                      TMO_W'($urandom_range(100, 100000)));
        end
        3: load_config(MIN_RANGE_RST, MAX_RANGE_RST, HOLDOFF_RST, TIMEOUT_RST);
        default: begin
          mn = RANGE_W'($urandom_range(0, 3000));
          load_config(mn, mn + RANGE_W'($urandom_range(0, 8000)),
                      HOLD_W'($urandom_range(0, 2000)),
                      TMO_W'($urandom_range(1, 24'hFF_FFFF)));
        end
      endcase
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
        sel = $urandom_range(0, 99);
        if (sel < 65) begin
          reading_sequence();
        end else if (sel < 80) begin
          timeout_sequence();
        end else if ($urandom_range(0, 1) == 1) begin
          send_event(OP_W'($urandom_range(0, 3)), 1'($urandom),
                     now + $urandom_range(0, 2 * cur_hold + 10));
        end else begin
          send_event(OP_W'($urandom_range(0, 3)), 1'($urandom), $urandom());
        end
      end
    end

    settle();
    if (tracker.errors == 0 && tracker.due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
